>>> design/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions for the soft timer table
// Operation codes, field widths, default channel count and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Field widths of one beat
    localparam int MODE_W    = 3;
    localparam int INDEX_W   = 4;
    localparam int TIMEOUT_W = 32;
    localparam int FIRED_W   = 16;

    // Default number of timer channels
    localparam int NUM_TIMERS_DEF = 16;

    // Operation codes carried by the mode field
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted operation
        logic exec;   // apply it to the table and fill the result register
    } stt_cmd_t;

endpackage

>>> design/stt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ctrl: soft timer table controller
// Two-state sequencer: take one beat, apply it once the result register
// is free, and track the valid flag of the result register.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output stt_pkg::stt_cmd_t cmd
);
    import stt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;

    // Result register can take a new value this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = s_valid && (state_reg == ST_IDLE);
    assign cmd.exec = (state_reg == ST_EXEC) && out_free;
    assign m_valid  = m_valid_reg;

    // Advance the sequencer; hold in execute while the result is stalled
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.exec) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set valid on execute, drop it when the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // An accepted beat is always followed by the execute state
    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("stt_ctrl: accepted beat did not enter execute");

    // Executing always presents a result in the next cycle
    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("stt_ctrl: execute did not fill the result register");

    // A stalled result blocks the pending operation
    a_stall_holds_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) && m_valid_reg && !m_ready |=>
        (state_reg == ST_EXEC) && m_valid_reg)
        else $error("stt_ctrl: pending operation overwrote a stalled result");

endmodule

>>> design/stt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_datapath: soft timer table channel state and result register
// Holds the per-channel flags, timeouts and counters, the tick enable
// register, the captured operation and the result of the last operation.
// ----------------------------------------------------------------------------
module stt_datapath #(
    parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  stt_pkg::stt_cmd_t              cmd,
    input  logic [stt_pkg::MODE_W-1:0]     s_mode,
    input  logic [stt_pkg::INDEX_W-1:0]    s_timer_index,
    input  logic [stt_pkg::TIMEOUT_W-1:0]  s_timeout_ticks,
    input  logic                           s_periodic,
    output logic                           m_status,
    output logic [stt_pkg::INDEX_W-1:0]    m_allocated_index,
    output logic [stt_pkg::FIRED_W-1:0]    m_fired_mask
);
    import stt_pkg::*;

    // Channels that own a bit in the fired mask
    localparam int FM_LANES = (NUM_TIMERS < FIRED_W) ? NUM_TIMERS : FIRED_W;

    // Configuration
    logic tick_en_reg;

    // Captured operation
    logic [MODE_W-1:0]    op_mode_reg;
    logic [INDEX_W-1:0]   op_idx_reg;
    logic [TIMEOUT_W-1:0] op_tmo_reg;
    logic                 op_per_reg;

    // Channel table
    logic [NUM_TIMERS-1:0] alloc_reg;
    logic [NUM_TIMERS-1:0] alloc_next;
    logic [NUM_TIMERS-1:0] run_reg;
    logic [NUM_TIMERS-1:0] run_next;
    logic [NUM_TIMERS-1:0] per_reg;
    logic [NUM_TIMERS-1:0] per_next;
    logic [TIMEOUT_W-1:0]  tmo_reg  [NUM_TIMERS];
    logic [TIMEOUT_W-1:0]  tmo_next [NUM_TIMERS];
    logic [TIMEOUT_W-1:0]  cnt_reg  [NUM_TIMERS];
    logic [TIMEOUT_W-1:0]  cnt_next [NUM_TIMERS];

    // Result register
    logic                 status_reg;
    logic                 status_next;
    logic [INDEX_W-1:0]   grant_reg;
    logic [INDEX_W-1:0]   grant_next;
    logic [FIRED_W-1:0]   fired_reg;
    logic [FIRED_W-1:0]   fired_next;

    // Per-lane helpers
    logic [NUM_TIMERS-1:0] sel;
    logic [NUM_TIMERS-1:0] hit;
    logic [NUM_TIMERS-1:0] lowest_free;
    logic [TIMEOUT_W-1:0]  cnt_inc [NUM_TIMERS];
    logic                  in_range;
    logic                  sel_alloc;
    logic                  any_free;
    logic [INDEX_W-1:0]    free_idx;
    logic [FIRED_W-1:0]    tick_mask;

    // Decode the addressed channel and the tick outcome of every lane
    always_comb begin
        in_range = int'(op_idx_reg) < NUM_TIMERS;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            sel[i]     = in_range && (int'(op_idx_reg) == i);
            cnt_inc[i] = cnt_reg[i] + TIMEOUT_W'(1);
            hit[i]     = alloc_reg[i] && run_reg[i] && (cnt_inc[i] >= tmo_reg[i]);
        end
        sel_alloc = |(sel & alloc_reg);
    end

    // Find the lowest free channel: lowest clear bit of the allocated set
    always_comb begin
        lowest_free = ~alloc_reg & (alloc_reg + NUM_TIMERS'(1));
        any_free    = |(~alloc_reg);
        free_idx    = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (lowest_free[i]) begin
                free_idx = free_idx | INDEX_W'(i);
            end
        end
    end

    // Collect the fired bits that fit in the mask
    always_comb begin
        tick_mask = '0;
        for (int i = 0; i < FM_LANES; i++) begin
            tick_mask[i] = hit[i];
        end
    end

    // Apply the captured operation to the table and build the result
    always_comb begin
        alloc_next  = alloc_reg;
        run_next    = run_reg;
        per_next    = per_reg;
        tmo_next    = tmo_reg;
        cnt_next    = cnt_reg;
        status_next = 1'b0;
        grant_next  = '0;
        fired_next  = '0;
        case (op_mode_reg)
            MODE_TICK: begin
                if (tick_en_reg) begin
                    fired_next = tick_mask;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (alloc_reg[i] && run_reg[i]) begin
                            cnt_next[i] = hit[i] ? '0 : cnt_inc[i];
                            if (hit[i] && !per_reg[i]) begin
                                run_next[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            MODE_ALLOC: begin
                if (any_free) begin
                    alloc_next = alloc_reg | lowest_free;
                    run_next   = run_reg & ~lowest_free;
                    per_next   = per_reg & ~lowest_free;
                    grant_next = free_idx;
                end else begin
                    status_next = 1'b1;
                end
            end
            MODE_FREE: begin
                if (!in_range) begin
                    status_next = 1'b1;
                end else begin
                    alloc_next = alloc_reg & ~sel;
                    run_next   = run_reg & ~sel;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (sel[i]) begin
                            tmo_next[i] = '0;
                        end
                    end
                end
            end
            MODE_START: begin
                if (!sel_alloc || (op_tmo_reg == '0)) begin
                    status_next = 1'b1;
                end else begin
                    run_next = run_reg | sel;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (sel[i]) begin
                            tmo_next[i] = op_tmo_reg;
                            cnt_next[i] = '0;
                            per_next[i] = op_per_reg;
                        end
                    end
                end
            end
            MODE_STOP: begin
                if (!sel_alloc) begin
                    status_next = 1'b1;
                end else begin
                    run_next = run_reg & ~sel;
                end
            end
            default: begin
                status_next = 1'b1;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            tick_en_reg <= cfg_wr_data;
        end
    end

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_mode_reg <= s_mode;
            op_idx_reg  <= s_timer_index;
            op_tmo_reg  <= s_timeout_ticks;
            op_per_reg  <= s_periodic;
        end
    end

    // Channel flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= '0;
            run_reg   <= '0;
            per_reg   <= '0;
        end else if (cmd.exec) begin
            alloc_reg <= alloc_next;
            run_reg   <= run_next;
            per_reg   <= per_next;
        end
    end

    // Channel timeouts and counters, meaningful only once started
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            tmo_reg <= tmo_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            fired_reg  <= fired_next;
        end
    end

    assign m_status          = status_reg;
    assign m_allocated_index = grant_reg;
    assign m_fired_mask      = fired_reg;

endmodule

>>> design/soft_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_timer_table: table of software timer channels
// Each beat is one operation (tick, allocate, free, start, stop) and
// returns one result beat with status, granted channel and fired mask.
//
//   Channel  Handshake           Payload
//   s_       s_valid / s_ready   s_mode, s_timer_index, s_timeout_ticks,
//                                s_periodic
//   m_       m_valid / m_ready   m_status, m_allocated_index, m_fired_mask
//   cfg_     cfg_wr_en           cfg_wr_data (tick enable)
//
// Each beat is first captured; then every channel lane updates in
// parallel and the result register loads.
// The next beat is accepted while the previous result still waits.
// A stalled result holds the execute cycle of the next beat until taken.
// Synchronous reset clears all channels and sets tick enable; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module soft_timer_table #(
    parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [stt_pkg::MODE_W-1:0]     s_mode,
    input  logic [stt_pkg::INDEX_W-1:0]    s_timer_index,
    input  logic [stt_pkg::TIMEOUT_W-1:0]  s_timeout_ticks,
    input  logic                           s_periodic,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_status,
    output logic [stt_pkg::INDEX_W-1:0]    m_allocated_index,
    output logic [stt_pkg::FIRED_W-1:0]    m_fired_mask
);
    import stt_pkg::*;

    stt_cmd_t cmd;

    // Sequencer
    stt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Channel table and result register
    stt_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .s_mode            (s_mode),
        .s_timer_index     (s_timer_index),
        .s_timeout_ticks   (s_timeout_ticks),
        .s_periodic        (s_periodic),
        .m_status          (m_status),
        .m_allocated_index (m_allocated_index),
        .m_fired_mask      (m_fired_mask)
    );

endmodule
